### sv/esr_pkg.sv
package esr_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned KEY_WIDTH_DEF  = 32;
  localparam int unsigned IDX_W_DEF      = 4;

  // operation codes
  localparam logic [1:0] OP_ENABLE  = 2'd0;
  localparam logic [1:0] OP_DISABLE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // status codes
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_PRESENT    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_REMOVED    = 3'd3;
  localparam logic [2:0] ST_ABSENT_DIS = 3'd4;
  localparam logic [2:0] ST_FOUND      = 3'd5;
  localparam logic [2:0] ST_ABSENT_QRY = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [3:0] rank;
    logic [4:0] entry_count;
  } out_item_t;

  // search token flags handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic free_hit;
  } flags_t;

endpackage

### sv/esr_cell.sv
module esr_cell #(
  parameter int unsigned KEY_WIDTH = esr_pkg::KEY_WIDTH_DEF,
  parameter int unsigned IDX_W     = esr_pkg::IDX_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic                 set_i,
  input  logic                 clr_i,
  input  esr_pkg::flags_t      flg_i,
  input  logic [IDX_W-1:0]     pos_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  input  logic [IDX_W-1:0]     rank_i,
  output esr_pkg::flags_t      flg_o,
  output logic [IDX_W-1:0]     pos_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [IDX_W-1:0]     rank_o,
  output logic                 valid_o
);

  logic                 valid_q;
  logic [KEY_WIDTH-1:0] key_q;
  esr_pkg::flags_t      flg_q, flg_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [IDX_W-1:0]     rank_q, rank_d;
  logic                 mine;

  always_comb begin
    mine              = valid_q && (key_q == key_i);
    flg_d.active      = flg_i.active;
    flg_d.hit         = flg_i.hit | mine;
    flg_d.free_hit    = flg_i.free_hit | ~valid_q;
    hit_idx_d         = (!flg_i.hit && mine) ? pos_i : hit_idx_i;
    free_idx_d        = (!flg_i.free_hit && !valid_q) ? pos_i : free_idx_i;
    // occupied slots below the first match
    rank_d            = (!flg_i.hit && !mine && valid_q) ? rank_i + 1'b1 : rank_i;
    pos_d             = pos_i + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flg_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      flg_q <= flg_d;
      if (set_i) begin
        valid_q <= 1'b1;
      end else if (clr_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    rank_q     <= rank_d;
    if (set_i) begin
      key_q <= key_i;
    end
  end

  assign flg_o      = flg_q;
  assign pos_o      = pos_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign rank_o     = rank_q;
  assign valid_o    = valid_q;

endmodule

### sv/enabled_slot_set_with_rank_core.sv
// Set of up to SLOT_COUNT keys held in a row of slot cells, each cell keeping one key and
// its valid mark. An accepted word starts a search token that walks the row one cell per
// cycle, picking up the lowest matching slot, the lowest free slot and the number of
// occupied slots below the match. When the token leaves the last cell the set is updated
// (enable fills the free slot, disable clears the matched one) and the result is formed.
// One word is in the row at a time: the next input word is taken only once the token of the
// previous one has left the last cell and the spare register is empty. A finished result
// waits in an output register plus one spare register, so the next word can enter while a
// result waits in the output register, but not while the spare register is full.
// Slot keys are unset after reset; valid marks, the count and control flags are cleared.
module enabled_slot_set_with_rank_core #(
  parameter int unsigned SLOT_COUNT = esr_pkg::SLOT_COUNT_DEF,
  parameter int unsigned KEY_WIDTH  = esr_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  esr_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output esr_pkg::out_item_t out_item_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  logic                 busy_q;
  logic                 head_act_q;
  logic [1:0]           op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic                 accept;

  esr_pkg::flags_t  flg      [SLOT_COUNT+1];
  logic [IDX_W-1:0] pos      [SLOT_COUNT+1];
  logic [IDX_W-1:0] hit_idx  [SLOT_COUNT+1];
  logic [IDX_W-1:0] free_idx [SLOT_COUNT+1];
  logic [IDX_W-1:0] rank     [SLOT_COUNT+1];

  logic [SLOT_COUNT-1:0] set_vec, clr_vec, slot_vld;
  logic                  set_go, clr_go;
  esr_pkg::flags_t       tail;
  logic [IDX_W-1:0]      tail_hit_idx, tail_free_idx, tail_rank;

  esr_pkg::out_item_t res;
  esr_pkg::out_item_t out_q, out_d, hold_q, hold_d;
  logic               out_vld_q, out_vld_d, hold_vld_q, hold_vld_d;
  logic               out_free;

  assign in_ready_o = !busy_q && !hold_vld_q;
  assign accept     = in_valid_i && in_ready_o;

  // token entry into the first cell
  assign flg[0]      = '{active: head_act_q, hit: 1'b0, free_hit: 1'b0};
  assign pos[0]      = '0;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign rank[0]     = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    assign set_vec[i] = set_go && (tail_free_idx == IDX_W'(i));
    assign clr_vec[i] = clr_go && (tail_hit_idx == IDX_W'(i));

    esr_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key_q),
      .set_i      (set_vec[i]),
      .clr_i      (clr_vec[i]),
      .flg_i      (flg[i]),
      .pos_i      (pos[i]),
      .hit_idx_i  (hit_idx[i]),
      .free_idx_i (free_idx[i]),
      .rank_i     (rank[i]),
      .flg_o      (flg[i+1]),
      .pos_o      (pos[i+1]),
      .hit_idx_o  (hit_idx[i+1]),
      .free_idx_o (free_idx[i+1]),
      .rank_o     (rank[i+1]),
      .valid_o    (slot_vld[i])
    );
  end

  assign tail          = flg[SLOT_COUNT];
  assign tail_hit_idx  = hit_idx[SLOT_COUNT];
  assign tail_free_idx = free_idx[SLOT_COUNT];
  assign tail_rank     = rank[SLOT_COUNT];

  // result and set update when the token leaves the row
  always_comb begin
    res        = '0;
    set_go     = 1'b0;
    clr_go     = 1'b0;
    occ_d      = occ_q;
    unique case (op_q)
      esr_pkg::OP_ENABLE: begin
        if (tail.hit) begin
          res.status     = esr_pkg::ST_PRESENT;
          res.slot_index = 4'(tail_hit_idx);
        end else if (tail.free_hit) begin
          res.status     = esr_pkg::ST_ADDED;
          res.slot_index = 4'(tail_free_idx);
          set_go         = tail.active;
          occ_d          = occ_q + 1'b1;
        end else begin
          res.status = esr_pkg::ST_FULL;
        end
      end
      esr_pkg::OP_DISABLE: begin
        if (tail.hit) begin
          res.status     = esr_pkg::ST_REMOVED;
          res.slot_index = 4'(tail_hit_idx);
          clr_go         = tail.active;
          occ_d          = occ_q - 1'b1;
        end else begin
          res.status = esr_pkg::ST_ABSENT_DIS;
        end
      end
      default: begin
        // query, and the unused code acts as one
        if (tail.hit) begin
          res.status     = esr_pkg::ST_FOUND;
          res.slot_index = 4'(tail_hit_idx);
          res.rank       = 4'(tail_rank);
        end else begin
          res.status = esr_pkg::ST_ABSENT_QRY;
        end
      end
    endcase
    res.entry_count = 5'(occ_d);
  end

  // output word plus one spare register
  always_comb begin
    out_free   = !out_vld_q || out_ready_i;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    if (tail.active) begin
      if (out_free) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        hold_d     = res;
        hold_vld_d = 1'b1;
      end
    end else if (hold_vld_q && out_free) begin
      out_d      = hold_q;
      out_vld_d  = 1'b1;
      hold_vld_d = 1'b0;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      head_act_q <= 1'b0;
      occ_q      <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      head_act_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.active) begin
        busy_q <= 1'b0;
      end
      if (tail.active) begin
        occ_q <= occ_d;
      end
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_item_i.operation;
      key_q <= KEY_WIDTH'(in_item_i.key);
    end
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_tail_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |-> busy_q)
    else $error("search token left the row with no word in flight");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(slot_vld)))
    else $error("entry count differs from number of valid slots");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(SLOT_COUNT))
    else $error("entry count above capacity");

  a_one_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({set_vec, clr_vec}))
    else $error("more than one slot updated at once");

  a_hold_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> out_vld_q)
    else $error("spare register filled while output register empty");
`endif

endmodule
